// ----- hdl/rpfc_pkg.sv -----
// Shared types and constants for the RF pulse frame capture block.
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

	// Field and datapath widths.
	localparam int WIDTH_W    = 16;
	localparam int IDX_W      = 6;
	localparam int LEN_W      = 7;
	localparam int RATE_W     = 30;
	localparam int TICK_W     = 17;
	localparam int PROD_W     = 37;
	localparam int QUOT_W     = 16;
	localparam int DSR_W      = RATE_W + QUOT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;
	localparam int CONST_W    = 20;

	// Arithmetic constants.
	localparam logic [CONST_W-1:0] US_PER_S     = 20'd1000000;
	localparam logic [RATE_W-1:0]  RATE_DEFAULT = 30'd1000000;
	localparam logic [WIDTH_W-1:0] WIDTH_SAT    = 16'hFFFF;

	// Register reset values.
	localparam logic [WIDTH_W-1:0] PERIOD_RST  = 16'd65535;
	localparam logic [WIDTH_W-1:0] MIN_W_RST   = 16'd80;
	localparam logic [WIDTH_W-1:0] MAX_W_RST   = 16'd60000;
	localparam logic [WIDTH_W-1:0] SYNC_W_RST  = 16'd8000;
	localparam logic [LEN_W-1:0]   MIN_LEN_RST = 7'd48;

	// Item commands.
	typedef enum logic [1:0] {
		CMD_CAPTURE = 2'd0,
		CMD_WIDTH   = 2'd1,
		CMD_FLUSH   = 2'd2
	} cmd_e_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMER_RATE  = 3'd0,
		REG_WRAP_PERIOD = 3'd1,
		REG_MIN_WIDTH   = 3'd2,
		REG_MAX_WIDTH   = 3'd3,
		REG_SYNC_WIDTH  = 3'd4,
		REG_MIN_LEN     = 3'd5
	} reg_e_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_RD,
		ST_LOAD,
		ST_STORE0
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_load;
		logic cap_first;
		logic cap_step;
		logic sat_load;
		logic direct_load;
		logic mul;
		logic div_start;
		logic div_load;
		logic store;
		logic clear_cnt;
		logic rd_start;
		logic rd_issue;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_e_t cmd;
		logic   known_cmd;
		logic   have_prev;
		logic   cap_neg;
		logic   drop;
		logic   sync_close;
		logic   full;
		logic   emit_ok;
		logic   div_done;
		logic   rd_last;
		logic   out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/rpfc_pulse_if.sv -----
// Input channel carrying capture values, direct widths and flush commands.
`timescale 1ns / 1ps
`default_nettype none

interface rpfc_pulse_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/rpfc_frame_if.sv -----
// Output channel carrying the widths of an emitted frame.
`timescale 1ns / 1ps
`default_nettype none

interface rpfc_frame_if;
	logic        valid;
	logic        ready;
	logic [15:0] width_us;
	logic [5:0]  pulse_index;
	logic [6:0]  frame_len;
	logic        last;

	modport source (output valid, output width_us, output pulse_index, output frame_len,
		output last, input ready);
	modport sink   (input valid, input width_us, input pulse_index, input frame_len,
		input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/rpfc_cfg_if.sv -----
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface rpfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [29:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rf_pulse_frame_capture.sv -----
// Top level of the RF pulse frame capture block.
`timescale 1ns / 1ps
`default_nettype none

// Collects on-off-keyed pulse widths into frames and emits each finished frame as a
// run of widths. Items are taken one at a time; a timer capture is converted by the
// 17-step restoring divider that turns ticks into microseconds (one trial subtraction
// per cycle, ending early on saturation), while a direct width bypasses it. A frame
// that closes is read from the frame store one width at a time, each waiting for
// a free output register, before the next item is taken. The last width of a frame
// waits in the output register while the next item is already accepted.
// Configuration writes are accepted in any cycle and must only be issued while no
// item is in work.
module rf_pulse_frame_capture #(
	parameter int FRAME_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rpfc_pulse_if.sink   pulse_in,
	rpfc_frame_if.source frame_out,
	rpfc_cfg_if.sink     cfg
);

	rpfc_pkg::ctrl_cmd_t ctrl_cmd;
	rpfc_pkg::dp_stat_t  dp_stat;
	logic                in_ready;

	assign pulse_in.ready = in_ready;
	assign cfg.ready      = 1'b1;

	rpfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pulse_in.valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	rpfc_datapath #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctrl_cmd),
		.stat            (dp_stat),
		.in_cmd          (pulse_in.cmd),
		.in_value        (pulse_in.value),
		.cfg_valid       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_ready       (frame_out.ready),
		.out_valid       (frame_out.valid),
		.out_width_us    (frame_out.width_us),
		.out_pulse_index (frame_out.pulse_index),
		.out_frame_len   (frame_out.frame_len),
		.out_last        (frame_out.last)
	);

endmodule

`default_nettype wire

// ----- hdl/rpfc_div.sv -----
// Iterative restoring divider for the tick to microsecond conversion.
`timescale 1ns / 1ps
`default_nettype none

module rpfc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rpfc_pkg::PROD_W-1:0]   dividend,
	input  wire logic [rpfc_pkg::RATE_W-1:0]   divisor,
	output logic                               done,
	output logic                               sat,
	output logic [rpfc_pkg::QUOT_W-1:0]        quot
);

	localparam int STEP_W = $clog2(rpfc_pkg::QUOT_W + 1);
	localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(rpfc_pkg::QUOT_W);

	logic                          busy_q;
	logic                          done_q;
	logic                          sat_q;
	logic [STEP_W-1:0]             step_q;
	logic [rpfc_pkg::PROD_W-1:0]   rem_q;
	logic [rpfc_pkg::DSR_W-1:0]    dsr_q;
	logic [rpfc_pkg::QUOT_W-1:0]   quot_q;
	logic [rpfc_pkg::DSR_W-1:0]    rem_ext;
	logic [rpfc_pkg::DSR_W-1:0]    diff;
	logic                          ge;

	// One trial subtraction per cycle.
	assign rem_ext = rpfc_pkg::DSR_W'(rem_q);
	assign ge      = rem_ext >= dsr_q;
	assign diff    = rem_ext - dsr_q;

	// The first step tests the quotient against 65536 and stops early on saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sat_q  <= 1'b0;
				step_q <= STEP_TOP;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_TOP && ge) begin
					sat_q  <= 1'b1;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, shifted divisor and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsr_q  <= {divisor, rpfc_pkg::QUOT_W'(0)};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[rpfc_pkg::PROD_W-1:0];
			end
			dsr_q <= dsr_q >> 1;
			if (step_q != STEP_TOP) begin
				quot_q <= {quot_q[rpfc_pkg::QUOT_W-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ----- hdl/rpfc_datapath.sv -----
// Datapath: configuration registers, tick arithmetic, frame store and output register.
`timescale 1ns / 1ps
`default_nettype none

module rpfc_datapath #(
	parameter int FRAME_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rpfc_pkg::ctrl_cmd_t               cmd,
	output rpfc_pkg::dp_stat_t                     stat,
	input  wire logic [1:0]                        in_cmd,
	input  wire logic [rpfc_pkg::WIDTH_W-1:0]      in_value,
	input  wire logic                              cfg_valid,
	input  wire logic [rpfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [rpfc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [rpfc_pkg::WIDTH_W-1:0]           out_width_us,
	output logic [rpfc_pkg::IDX_W-1:0]             out_pulse_index,
	output logic [rpfc_pkg::LEN_W-1:0]             out_frame_len,
	output logic                                   out_last
);

	localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
	localparam int ADDR_W = $clog2(FRAME_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FRAME_DEPTH);

	// Configuration registers.
	logic [rpfc_pkg::RATE_W-1:0]  rate_q;
	logic [rpfc_pkg::WIDTH_W-1:0] period_q;
	logic [rpfc_pkg::WIDTH_W-1:0] min_w_q;
	logic [rpfc_pkg::WIDTH_W-1:0] max_w_q;
	logic [rpfc_pkg::WIDTH_W-1:0] sync_w_q;
	logic [rpfc_pkg::LEN_W-1:0]   min_len_q;

	// Item and arithmetic registers.
	logic [1:0]                   in_cmd_q;
	logic [rpfc_pkg::WIDTH_W-1:0] in_val_q;
	logic [rpfc_pkg::WIDTH_W-1:0] prev_q;
	logic                         have_prev_q;
	logic [rpfc_pkg::TICK_W-1:0]  ticks_q;
	logic [rpfc_pkg::PROD_W-1:0]  prod_q;
	logic [rpfc_pkg::WIDTH_W-1:0] w_q;

	// Frame store and readout.
	logic [rpfc_pkg::WIDTH_W-1:0] mem [FRAME_DEPTH];
	logic [CNT_W-1:0]             cnt_q;
	logic [ADDR_W-1:0]            rd_idx_q;
	logic [rpfc_pkg::WIDTH_W-1:0] rdata_q;

	// Output register.
	logic                         out_valid_q;
	logic [rpfc_pkg::WIDTH_W-1:0] ow_q;
	logic [rpfc_pkg::IDX_W-1:0]   opi_q;
	logic [rpfc_pkg::LEN_W-1:0]   ofl_q;
	logic                         olast_q;

	logic [rpfc_pkg::TICK_W:0]    tick_wrap;
	logic [rpfc_pkg::TICK_W-1:0]  tick_direct;
	logic                         cap_lt;
	logic [rpfc_pkg::RATE_W-1:0]  rate_eff;
	logic                         div_done;
	logic                         div_sat;
	logic [rpfc_pkg::QUOT_W-1:0]  div_quot;
	logic [rpfc_pkg::LEN_W-1:0]   cnt_ext;
	logic                         len_ok;
	logic                         rd_last;
	logic                         out_free;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= rpfc_pkg::RATE_DEFAULT;
			period_q  <= rpfc_pkg::PERIOD_RST;
			min_w_q   <= rpfc_pkg::MIN_W_RST;
			max_w_q   <= rpfc_pkg::MAX_W_RST;
			sync_w_q  <= rpfc_pkg::SYNC_W_RST;
			min_len_q <= rpfc_pkg::MIN_LEN_RST;
		end else if (cfg_valid) begin
			unique case (rpfc_pkg::reg_e_t'(cfg_index))
				rpfc_pkg::REG_TIMER_RATE:  rate_q    <= cfg_data;
				rpfc_pkg::REG_WRAP_PERIOD: period_q  <= cfg_data[rpfc_pkg::WIDTH_W-1:0];
				rpfc_pkg::REG_MIN_WIDTH:   min_w_q   <= cfg_data[rpfc_pkg::WIDTH_W-1:0];
				rpfc_pkg::REG_MAX_WIDTH:   max_w_q   <= cfg_data[rpfc_pkg::WIDTH_W-1:0];
				rpfc_pkg::REG_SYNC_WIDTH:  sync_w_q  <= cfg_data[rpfc_pkg::WIDTH_W-1:0];
				rpfc_pkg::REG_MIN_LEN:     min_len_q <= cfg_data[rpfc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Tick distance; a wrapped sum below zero saturates the width.
	assign cap_lt      = in_val_q < prev_q;
	assign tick_direct = {1'b0, in_val_q} - {1'b0, prev_q};
	assign tick_wrap   = {2'b00, period_q} + (rpfc_pkg::TICK_W + 1)'(1)
		+ {2'b00, in_val_q} - {2'b00, prev_q};

	// A zero tick rate stands for the default rate.
	assign rate_eff = (rate_q == '0) ? rpfc_pkg::RATE_DEFAULT : rate_q;

	// Item capture, capture history and width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
		end else begin
			if (cmd.cap_first || cmd.cap_step) begin
				prev_q <= in_val_q;
			end
			if (cmd.cap_first) begin
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_cmd_q <= in_cmd;
			in_val_q <= in_value;
		end
		if (cmd.cap_step) begin
			ticks_q <= cap_lt ? tick_wrap[rpfc_pkg::TICK_W-1:0] : tick_direct;
		end
		if (cmd.mul) begin
			prod_q <= rpfc_pkg::PROD_W'(ticks_q) * rpfc_pkg::PROD_W'(rpfc_pkg::US_PER_S);
		end
		if (cmd.sat_load) begin
			w_q <= rpfc_pkg::WIDTH_SAT;
		end else if (cmd.direct_load) begin
			w_q <= in_val_q;
		end else if (cmd.div_load) begin
			w_q <= div_sat ? rpfc_pkg::WIDTH_SAT : div_quot;
		end
	end

	rpfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (rate_eff),
		.done     (div_done),
		.sat      (div_sat),
		.quot     (div_quot)
	);

	// Fill count and readout index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.rd_start) begin
				rd_idx_q <= '0;
			end else if (cmd.out_load) begin
				rd_idx_q <= rd_idx_q + ADDR_W'(1);
			end
		end
	end

	// Frame store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[cnt_q[ADDR_W-1:0]] <= w_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rdata_q <= mem[rd_idx_q];
		end
	end

	// Output register, refilled while the previous item is taken.
	assign out_free = !out_valid_q || out_ready;
	assign rd_last  = (CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ow_q    <= rdata_q;
			opi_q   <= rpfc_pkg::IDX_W'(rd_idx_q);
			ofl_q   <= rpfc_pkg::LEN_W'(cnt_q);
			olast_q <= rd_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_width_us    = ow_q;
	assign out_pulse_index = opi_q;
	assign out_frame_len   = ofl_q;
	assign out_last        = olast_q;

	// Status for the controller.
	assign cnt_ext = rpfc_pkg::LEN_W'(cnt_q);
	assign len_ok  = cnt_ext >= min_len_q;

	always_comb begin
		stat            = '0;
		stat.cmd        = rpfc_pkg::cmd_e_t'(in_cmd_q);
		stat.known_cmd  = in_cmd_q == rpfc_pkg::CMD_CAPTURE || in_cmd_q == rpfc_pkg::CMD_WIDTH
			|| in_cmd_q == rpfc_pkg::CMD_FLUSH;
		stat.have_prev  = have_prev_q;
		stat.cap_neg    = cap_lt && tick_wrap[rpfc_pkg::TICK_W];
		stat.drop       = (w_q == '0) || (w_q < min_w_q) || (w_q > max_w_q);
		stat.sync_close = (w_q > sync_w_q) && len_ok;
		stat.full       = cnt_q == DEPTH_CNT;
		stat.emit_ok    = (cnt_q != '0) && len_ok;
		stat.div_done   = div_done;
		stat.rd_last    = rd_last;
		stat.out_free   = out_free;
	end

	// A result is never written over one that waits to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register loaded while holding an untaken item");

	// The store is never written past its depth.
	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (cnt_q < DEPTH_CNT || cmd.clear_cnt))
		else $error("width stored into a full frame");

	// Readout only runs on a frame that holds widths.
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (cnt_q != '0 && CNT_W'(rd_idx_q) < cnt_q))
		else $error("readout index beyond the stored frame");

endmodule

`default_nettype wire

// ----- hdl/rpfc_ctrl.sv -----
// Controller state machine: sequences item decode, conversion, storage and frame readout.
`timescale 1ns / 1ps
`default_nettype none

module rpfc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire rpfc_pkg::dp_stat_t    stat,
	output rpfc_pkg::ctrl_cmd_t        cmd
);

	rpfc_pkg::state_t state_q;
	rpfc_pkg::state_t state_nxt;
	logic             pend_q;
	logic             pend_set;
	logic             pend_val;

	// State register and the flag for a width that waits until readout ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpfc_pkg::ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pend_set) begin
				pend_q <= pend_val;
			end else if (state_q == rpfc_pkg::ST_STORE0) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rpfc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = rpfc_pkg::ST_DECODE;
			end
			rpfc_pkg::ST_DECODE: begin
				state_nxt = rpfc_pkg::ST_IDLE;
				if (stat.known_cmd) begin
					unique case (stat.cmd)
						rpfc_pkg::CMD_CAPTURE: begin
							if (stat.have_prev) begin
								state_nxt = stat.cap_neg ? rpfc_pkg::ST_CHECK : rpfc_pkg::ST_MUL;
							end
						end
						rpfc_pkg::CMD_WIDTH: state_nxt = rpfc_pkg::ST_CHECK;
						rpfc_pkg::CMD_FLUSH: begin
							if (stat.emit_ok) state_nxt = rpfc_pkg::ST_RD;
						end
						default: state_nxt = rpfc_pkg::ST_IDLE;
					endcase
				end
			end
			rpfc_pkg::ST_MUL:    state_nxt = rpfc_pkg::ST_DIV_GO;
			rpfc_pkg::ST_DIV_GO: state_nxt = rpfc_pkg::ST_DIV_WAIT;
			rpfc_pkg::ST_DIV_WAIT: begin
				if (stat.div_done) state_nxt = rpfc_pkg::ST_CHECK;
			end
			rpfc_pkg::ST_CHECK: begin
				if (stat.drop) begin
					state_nxt = rpfc_pkg::ST_IDLE;
				end else if (stat.sync_close && stat.emit_ok) begin
					state_nxt = rpfc_pkg::ST_RD;
				end else if (!stat.full) begin
					state_nxt = rpfc_pkg::ST_IDLE;
				end else begin
					state_nxt = stat.emit_ok ? rpfc_pkg::ST_RD : rpfc_pkg::ST_IDLE;
				end
			end
			rpfc_pkg::ST_RD: state_nxt = rpfc_pkg::ST_LOAD;
			rpfc_pkg::ST_LOAD: begin
				if (stat.out_free) begin
					if (!stat.rd_last) begin
						state_nxt = rpfc_pkg::ST_RD;
					end else begin
						state_nxt = pend_q ? rpfc_pkg::ST_STORE0 : rpfc_pkg::ST_IDLE;
					end
				end
			end
			rpfc_pkg::ST_STORE0: state_nxt = rpfc_pkg::ST_IDLE;
			default: state_nxt = rpfc_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		pend_set = 1'b0;
		pend_val = 1'b0;
		unique case (state_q)
			rpfc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			rpfc_pkg::ST_DECODE: begin
				if (stat.known_cmd) begin
					unique case (stat.cmd)
						rpfc_pkg::CMD_CAPTURE: begin
							if (!stat.have_prev) begin
								cmd.cap_first = 1'b1;
							end else begin
								cmd.cap_step = 1'b1;
								cmd.sat_load = stat.cap_neg;
							end
						end
						rpfc_pkg::CMD_WIDTH: cmd.direct_load = 1'b1;
						rpfc_pkg::CMD_FLUSH: begin
							if (stat.emit_ok) begin
								cmd.rd_start = 1'b1;
								pend_set     = 1'b1;
							end else begin
								cmd.clear_cnt = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			rpfc_pkg::ST_MUL:    cmd.mul = 1'b1;
			rpfc_pkg::ST_DIV_GO: cmd.div_start = 1'b1;
			rpfc_pkg::ST_DIV_WAIT: begin
				cmd.div_load = stat.div_done;
			end
			rpfc_pkg::ST_CHECK: begin
				if (stat.drop) begin
					cmd = '0;
				end else if (stat.sync_close && stat.emit_ok) begin
					cmd.rd_start = 1'b1;
					pend_set     = 1'b1;
					pend_val     = 1'b1;
				end else if (!stat.full) begin
					cmd.store = 1'b1;
				end else if (stat.emit_ok) begin
					cmd.rd_start = 1'b1;
					pend_set     = 1'b1;
				end else begin
					cmd.clear_cnt = 1'b1;
				end
			end
			rpfc_pkg::ST_RD: cmd.rd_issue = 1'b1;
			rpfc_pkg::ST_LOAD: begin
				if (stat.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.clear_cnt = stat.rd_last;
				end
			end
			rpfc_pkg::ST_STORE0: cmd.store = 1'b1;
			default: ;
		endcase
	end

	// An accepted item is decoded in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == rpfc_pkg::ST_DECODE)
		else $error("accepted item not decoded");

	// A held width only exists while a frame is read out.
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == rpfc_pkg::ST_RD || state_q == rpfc_pkg::ST_LOAD
			|| state_q == rpfc_pkg::ST_STORE0))
		else $error("held width outside a frame readout");

	// The divider finishes only while the controller waits for it.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state_q == rpfc_pkg::ST_DIV_WAIT)
		else $error("divider result arrived outside the wait state");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the RF pulse frame capture block.
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH          = 64;
	localparam int IDLE_PCT       = 12;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 4000;

	// Command code that the block must ignore, and register indexes past the list.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] REG_BEYOND_0 = 3'd6;
	localparam logic [2:0] REG_BEYOND_1 = 3'd7;

	typedef struct packed {
		logic [rpfc_pkg::WIDTH_W-1:0] width_us;
		logic [rpfc_pkg::IDX_W-1:0]   pulse_index;
		logic [rpfc_pkg::LEN_W-1:0]   frame_len;
		logic                         last;
	} frame_word_t;

	logic clk = 1'b0;
	logic arst_n;

	rpfc_pulse_if pulse_ch();
	rpfc_frame_if frame_ch();
	rpfc_cfg_if   cfg_ch();

	rf_pulse_frame_capture #(.FRAME_DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pulse_in  (pulse_ch),
		.frame_out (frame_ch),
		.cfg       (cfg_ch)
	);

	// Predicted register contents.
	logic [rpfc_pkg::RATE_W-1:0]  rate_hz     = rpfc_pkg::RATE_DEFAULT;
	logic [rpfc_pkg::WIDTH_W-1:0] wrap_period = rpfc_pkg::PERIOD_RST;
	logic [rpfc_pkg::WIDTH_W-1:0] min_us      = rpfc_pkg::MIN_W_RST;
	logic [rpfc_pkg::WIDTH_W-1:0] max_us      = rpfc_pkg::MAX_W_RST;
	logic [rpfc_pkg::WIDTH_W-1:0] sync_us     = rpfc_pkg::SYNC_W_RST;
	logic [rpfc_pkg::LEN_W-1:0]   min_len     = rpfc_pkg::MIN_LEN_RST;

	// Predicted capture history and frame contents.
	logic [rpfc_pkg::WIDTH_W-1:0] last_capture = '0;
	logic                         capture_seen = 1'b0;
	logic [rpfc_pkg::WIDTH_W-1:0] pulse_store [DEPTH];
	int                           stored = 0;

	// Frame widths predicted but not yet seen at the output.
	frame_word_t frame_q [$];

	int n_errors      = 0;
	int send_idle_pct = IDLE_PCT;
	int stall_pct     = IDLE_PCT;
	int hold_seq      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Capture ticks to microseconds, with a zero rate read as the default rate.
	function automatic logic [rpfc_pkg::WIDTH_W-1:0] ticks_to_us(logic [31:0] ticks);
		logic [63:0] hz;
		logic [63:0] us;
		hz = (rate_hz == '0) ? 64'(rpfc_pkg::RATE_DEFAULT) : 64'(rate_hz);
		us = (64'(ticks) * 64'(rpfc_pkg::US_PER_S)) / hz;
		return (us > 64'(rpfc_pkg::WIDTH_SAT)) ? rpfc_pkg::WIDTH_SAT
			: us[rpfc_pkg::WIDTH_W-1:0];
	endfunction

	// A closing frame that is long enough produces one result per stored width.
	function automatic void close_frame();
		frame_word_t word;
		int i;
		if (stored >= int'(min_len)) begin
			for (i = 0; i < stored; i++) begin
				word.width_us    = pulse_store[i];
				word.pulse_index = rpfc_pkg::IDX_W'(i);
				word.frame_len   = rpfc_pkg::LEN_W'(stored);
				word.last        = (i == stored - 1);
				frame_q.push_back(word);
			end
		end
		stored = 0;
	endfunction

	// Filter a width, close and keep on a sync pulse, close and drop on a full store.
	function automatic void take_width(logic [rpfc_pkg::WIDTH_W-1:0] w);
		if (w == '0 || w < min_us || w > max_us)
			return;
		if (w > sync_us && stored >= int'(min_len))
			close_frame();
		if (stored < DEPTH) begin
			pulse_store[stored] = w;
			stored++;
		end else begin
			close_frame();
		end
	endfunction

	function automatic void predict_item(logic [1:0] c, logic [rpfc_pkg::WIDTH_W-1:0] v);
		logic [31:0] ticks;
		case (c)
			rpfc_pkg::CMD_CAPTURE: begin
				if (capture_seen) begin
					if (v >= last_capture)
						ticks = {16'd0, v} - {16'd0, last_capture};
					else
						ticks = {16'd0, wrap_period} + 32'd1 + {16'd0, v}
							- {16'd0, last_capture};
					take_width(ticks_to_us(ticks));
				end
				capture_seen = 1'b1;
				last_capture = v;
			end
			rpfc_pkg::CMD_WIDTH: begin
				take_width(v);
			end
			rpfc_pkg::CMD_FLUSH: begin
				close_frame();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void note_reg(logic [2:0] idx, logic [rpfc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			rpfc_pkg::REG_TIMER_RATE:  rate_hz = data[rpfc_pkg::RATE_W-1:0];
			rpfc_pkg::REG_WRAP_PERIOD: wrap_period = data[rpfc_pkg::WIDTH_W-1:0];
			rpfc_pkg::REG_MIN_WIDTH:   min_us = data[rpfc_pkg::WIDTH_W-1:0];
			rpfc_pkg::REG_MAX_WIDTH:   max_us = data[rpfc_pkg::WIDTH_W-1:0];
			rpfc_pkg::REG_SYNC_WIDTH:  sync_us = data[rpfc_pkg::WIDTH_W-1:0];
			rpfc_pkg::REG_MIN_LEN:     min_len = data[rpfc_pkg::LEN_W-1:0];
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	// Offer one item, possibly after a random gap, and predict it once accepted.
	// Valid is left high so that back-to-back items need no extra edge.
	task automatic send_item(input logic [1:0] c, input logic [rpfc_pkg::WIDTH_W-1:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			pulse_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pulse_ch.valid <= 1'b1;
		pulse_ch.cmd   <= c;
		pulse_ch.value <= v;
		do @(posedge clk); while (!pulse_ch.ready);
		predict_item(c, v);
	endtask

	// Send a width either directly or as the capture value that yields it.
	task automatic send_pulse(input int unsigned w);
		logic [63:0] hz;
		logic [63:0] ticks;
		logic [63:0] pos;
		hz = (rate_hz == '0) ? 64'(rpfc_pkg::RATE_DEFAULT) : 64'(rate_hz);
		if ($urandom_range(99) < 40) begin
			ticks = (64'(w) * hz) / 64'(rpfc_pkg::US_PER_S);
			pos = (64'(last_capture) + ticks) % (64'(wrap_period) + 64'd1);
			send_item(rpfc_pkg::CMD_CAPTURE, pos[rpfc_pkg::WIDTH_W-1:0]);
		end else begin
			send_item(rpfc_pkg::CMD_WIDTH, w[rpfc_pkg::WIDTH_W-1:0]);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx,
		input logic [rpfc_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		note_reg(idx, data);
	endtask

	// Write every register in index order, plus one index past the list.
	task automatic apply_config(input logic [rpfc_pkg::RATE_W-1:0] rate,
		input logic [rpfc_pkg::WIDTH_W-1:0] per,
		input logic [rpfc_pkg::WIDTH_W-1:0] lo, input logic [rpfc_pkg::WIDTH_W-1:0] hi,
		input logic [rpfc_pkg::WIDTH_W-1:0] sy, input logic [rpfc_pkg::LEN_W-1:0] len);
		write_reg(rpfc_pkg::REG_TIMER_RATE, rate);
		write_reg(rpfc_pkg::REG_WRAP_PERIOD, rpfc_pkg::CFG_DATA_W'(per));
		write_reg(rpfc_pkg::REG_MIN_WIDTH, rpfc_pkg::CFG_DATA_W'(lo));
		write_reg(rpfc_pkg::REG_MAX_WIDTH, rpfc_pkg::CFG_DATA_W'(hi));
		write_reg(rpfc_pkg::REG_SYNC_WIDTH, rpfc_pkg::CFG_DATA_W'(sy));
		write_reg(rpfc_pkg::REG_MIN_LEN, rpfc_pkg::CFG_DATA_W'(len));
		write_reg($urandom_range(1) ? REG_BEYOND_1 : REG_BEYOND_0,
			rpfc_pkg::CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop offering items, wait for every predicted width, then let a
	// resultless item still in work finish.
	task automatic drain();
		pulse_ch.valid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		logic [rpfc_pkg::RATE_W-1:0]  rate;
		logic [rpfc_pkg::WIDTH_W-1:0] per;
		logic [rpfc_pkg::LEN_W-1:0]   len;
		case ($urandom_range(9))
			0:       rate = '0;
			1:       rate = rpfc_pkg::RATE_W'($urandom_range(1, 1000000000));
			2, 3:    rate = rpfc_pkg::RATE_W'($urandom_range(250000, 4000000));
			default: rate = rpfc_pkg::RATE_DEFAULT;
		endcase
		case ($urandom_range(5))
			0:       per = rpfc_pkg::WIDTH_W'($urandom_range(1, 255));
			1, 2:    per = rpfc_pkg::WIDTH_W'($urandom_range(256, 65534));
			default: per = rpfc_pkg::PERIOD_RST;
		endcase
		case ($urandom_range(7))
			0:       len = '0;
			1:       len = rpfc_pkg::LEN_W'(DEPTH);
			2:       len = rpfc_pkg::LEN_W'($urandom_range(DEPTH + 1, 127));
			default: len = rpfc_pkg::LEN_W'($urandom_range(1, 12));
		endcase
		apply_config(rate, per, rpfc_pkg::WIDTH_W'($urandom_range(1, 300)),
			rpfc_pkg::WIDTH_W'($urandom_range(20000, 65535)),
			rpfc_pkg::WIDTH_W'($urandom_range(1000, 12000)), len);
	endtask

	// Reset settings: capture start, wrap, width limits, ignored command, short flush.
	task automatic test_reset_defaults();
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd0);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd100);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd16);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd0);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd79);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd80);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd60000);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd60001);
		send_item(CMD_UNUSED, 16'hFFFF);
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
	endtask

	// Zero rate, small period, a wrap that saturates, and sync pulses closing frames.
	task automatic test_capture_wrap_and_sync();
		drain();
		apply_config('0, 16'd100, 16'd1, 16'hFFFF, 16'd1000, 7'd1);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd50);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd10);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd60000);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd5);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd2000);
		send_item(rpfc_pkg::CMD_FLUSH, 16'hFFFF);
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
	endtask

	// Largest rate, zero minimum frame length and an empty flush.
	task automatic test_rate_extremes();
		drain();
		apply_config({rpfc_pkg::RATE_W{1'b1}}, rpfc_pkg::PERIOD_RST, 16'd1, 16'hFFFF,
			16'hFFFF, 7'd0);
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd0);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd1);
		send_item(rpfc_pkg::CMD_WIDTH, 16'hFFFF);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd1);
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
	endtask

	// Minimum above maximum, period of one, and a frame length no frame can reach.
	task automatic test_dropped_and_unreachable_length();
		drain();
		apply_config(rpfc_pkg::RATE_DEFAULT, 16'd1, 16'd500, 16'd400, rpfc_pkg::SYNC_W_RST,
			7'd127);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd450);
		send_item(rpfc_pkg::CMD_CAPTURE, 16'd0);
		drain();
		apply_config(rpfc_pkg::RATE_DEFAULT, rpfc_pkg::PERIOD_RST, 16'd400, 16'd500, 16'd450,
			7'd127);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd450);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd499);
		send_item(rpfc_pkg::CMD_WIDTH, 16'd40000);
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
	endtask

	// Fill the store past its depth while the output is held off, so the block
	// emits a full frame, drops the overflowing width and stalls its input.
	task automatic test_full_frame_backpressure();
		int k;
		drain();
		apply_config(rpfc_pkg::RATE_DEFAULT, rpfc_pkg::PERIOD_RST, 16'd1, 16'hFFFF, 16'hFFFF,
			rpfc_pkg::LEN_W'(DEPTH));
		send_item(rpfc_pkg::CMD_FLUSH, 16'd0);
		for (k = 0; k < 70; k++) begin
			// Start the hold a few widths before the store overflows.
			if (k == DEPTH - 4)
				hold_seq <= hold_seq + 1;
			send_pulse($urandom_range(1, 65535));
		end
	endtask

	// Random settings per round; mostly well-formed frames closed by a sync pulse
	// or a flush, with random items mixed in.
	task automatic test_random_frames(input int rounds, input int per_round);
		int r;
		int sent;
		int lo;
		int n;
		int k;
		bit paused;
		for (r = 0; r < rounds; r++) begin
			drain();
			random_config();
			// One round runs with no idling on either side.
			if (r == 2) begin
				send_idle_pct = 0;
				stall_pct <= 0;
			end else begin
				send_idle_pct = IDLE_PCT;
				stall_pct <= IDLE_PCT;
			end
			sent = 0;
			paused = 1'b0;
			while (sent < per_round) begin
				if (!paused && sent >= per_round / 2) begin
					drain();
					paused = 1'b1;
				end
				lo = int'(min_len);
				if (lo == 0)
					lo = 1;
				if (lo > DEPTH)
					lo = DEPTH;
				n = $urandom_range(lo, lo + 6);
				for (k = 0; k < n && sent < per_round; k++) begin
					if ($urandom_range(99) < 12) begin
						send_item(2'($urandom_range(0, 3)),
							rpfc_pkg::WIDTH_W'($urandom_range(0, 65535)));
						sent++;
					end
					send_pulse($urandom_range(min_us, sync_us));
					sent++;
				end
				if ($urandom_range(99) < 80)
					send_pulse($urandom_range(sync_us + 1, max_us));
				else
					send_item(rpfc_pkg::CMD_FLUSH,
						rpfc_pkg::WIDTH_W'($urandom_range(0, 65535)));
				sent++;
			end
		end
		send_idle_pct = IDLE_PCT;
		stall_pct <= IDLE_PCT;
	endtask

	// Output ready: random stalls, or a long hold when a test asks for one.
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			frame_ch.ready <= 1'b0;
		end else begin
			frame_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each accepted result with the oldest predicted width.
	always @(posedge clk) begin : check_results
		frame_word_t want;
		if (frame_ch.valid && frame_ch.ready) begin
			if (frame_q.size() == 0) begin
				$error("width_us %0d at pulse_index %0d arrived with nothing predicted",
					frame_ch.width_us, frame_ch.pulse_index);
				n_errors++;
			end else begin
				want = frame_q.pop_front();
				check_field("width_us", want.width_us, frame_ch.width_us);
				check_field("pulse_index", 16'(want.pulse_index), 16'(frame_ch.pulse_index));
				check_field("frame_len", 16'(want.frame_len), 16'(frame_ch.frame_len));
				check_field("last", 16'(want.last), 16'(frame_ch.last));
			end
		end
	end

	// End the run when no handshake has completed for too long.
	always @(posedge clk) begin
		if (!arst_n || (pulse_ch.valid && pulse_ch.ready) || (frame_ch.valid && frame_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pulse_ch.valid = 1'b0;
		pulse_ch.cmd   = '0;
		pulse_ch.value = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = '0;
		cfg_ch.data    = '0;
		frame_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_capture_wrap_and_sync();
		test_rate_extremes();
		test_dropped_and_unreachable_length();
		test_full_frame_backpressure();
		test_random_frames(5, 36);

		drain();
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
